// File: rtl/tbce_pkg.sv
// Package with the round function, S-box and constants of the tweakable block cipher.
package tbce_pkg;

    localparam int ROUNDS_DEFAULT = 56;
    localparam int CELLS = 16;

    typedef logic [0:CELLS-1][7:0] cells_t;

    typedef struct packed {
        cells_t s;
        cells_t tk1;
        cells_t tk2;
        cells_t tk3;
    } round_data_t;

    localparam logic [3:0] TK_PERM [CELLS] = '{
        4'd9, 4'd15, 4'd8, 4'd13, 4'd10, 4'd14, 4'd12, 4'd11,
        4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7
    };

    localparam logic [7:0] CELL8_CONST = 8'h02;

    function automatic logic [7:0] sbox8(input logic [7:0] v);
        logic [7:0] x;
        x = v;
        for (int r = 0; r < 4; r++) begin
            x[0] = x[0] ^ ~(x[3] | x[2]);
            x[4] = x[4] ^ ~(x[7] | x[6]);
            if (r < 3) begin
                x = {x[2], x[1], x[7], x[6], x[4], x[0], x[3], x[5]};
            end
            else begin
                x = {x[7:3], x[1], x[2], x[0]};
            end
        end
        return x;
    endfunction

    function automatic logic [5:0] round_const(input int round);
        logic [5:0] rc;
        rc = '0;
        for (int k = 0; k <= round; k++) begin
            rc = {rc[4:0], rc[5] ^ rc[4] ^ 1'b1};
        end
        return rc;
    endfunction

    function automatic round_data_t cipher_round(input round_data_t d, input logic [5:0] rc);
        round_data_t q;
        cells_t s;
        cells_t t;
        s = d.s;
        for (int i = 0; i < CELLS; i++) begin
            s[i] = sbox8(s[i]);
        end
        s[0] = s[0] ^ {4'b0000, rc[3:0]};
        s[4] = s[4] ^ {6'b000000, rc[5:4]};
        s[8] = s[8] ^ CELL8_CONST;
        for (int i = 0; i < 8; i++) begin
            s[i] = s[i] ^ d.tk1[i] ^ d.tk2[i] ^ d.tk3[i];
        end
        for (int i = 0; i < CELLS; i++) begin
            q.tk1[i] = d.tk1[TK_PERM[i]];
            q.tk2[i] = d.tk2[TK_PERM[i]];
            q.tk3[i] = d.tk3[TK_PERM[i]];
        end
        for (int i = 0; i < 8; i++) begin
            q.tk2[i] = {q.tk2[i][6:0], q.tk2[i][7] ^ q.tk2[i][5]};
            q.tk3[i] = {q.tk3[i][0] ^ q.tk3[i][6], q.tk3[i][7:1]};
        end
        t = s;
        for (int i = 0; i < 4; i++) begin
            s[4 + i]  = t[4 + ((i + 3) % 4)];
            s[8 + i]  = t[8 + ((i + 2) % 4)];
            s[12 + i] = t[12 + ((i + 1) % 4)];
        end
        t = s;
        for (int i = 0; i < 4; i++) begin
            s[i]      = t[i] ^ t[8 + i] ^ t[12 + i];
            s[4 + i]  = t[i];
            s[8 + i]  = t[4 + i] ^ t[8 + i];
            s[12 + i] = t[i] ^ t[8 + i];
        end
        q.s = s;
        return q;
    endfunction

endpackage

// File: rtl/tweakable_block_cipher_encrypt.sv
// Fully unrolled round pipeline of the tweakable block cipher, encryption only.
// Every round has its own registered stage between an input transfer and the output.
// One block per cycle unless m_tready stalls; each stage has a valid bit and ready term.
// A stage takes a new block whenever it is empty or its block moves on in the same cycle.
// Reset clears all valid bits asynchronously; the data registers are not reset.
module tweakable_block_cipher_encrypt
    import tbce_pkg::*;
#(
    parameter int ROUNDS = ROUNDS_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // plaintext_hi, plaintext_lo, tweakey1_hi, tweakey1_lo,
    // tweakey2_hi, tweakey2_lo, tweakey3_hi, tweakey3_lo
    input  logic [511:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // ciphertext_hi, ciphertext_lo
    output logic [127:0] m_tdata
);

    round_data_t in_data;
    round_data_t data_reg [ROUNDS];
    logic [ROUNDS-1:0] valid_reg;
    logic [ROUNDS-1:0] stage_ready;

    assign in_data.s   = {s_tdata[63:0],    s_tdata[127:64]};
    assign in_data.tk1 = {s_tdata[191:128], s_tdata[255:192]};
    assign in_data.tk2 = {s_tdata[319:256], s_tdata[383:320]};
    assign in_data.tk3 = {s_tdata[447:384], s_tdata[511:448]};

    assign stage_ready[ROUNDS-1] = !valid_reg[ROUNDS-1] || m_tready;

    genvar k;
    generate
        for (k = 0; k < ROUNDS - 1; k++) begin : g_ready
            assign stage_ready[k] = !valid_reg[k] || stage_ready[k + 1];
        end

        for (k = 0; k < ROUNDS; k++) begin : g_stage
            localparam logic [5:0] RC = round_const(k);
            round_data_t prev_data;
            logic        prev_valid;

            if (k == 0) begin : g_first
                assign prev_data  = in_data;
                assign prev_valid = s_tvalid;
            end
            else begin : g_rest
                assign prev_data  = data_reg[k - 1];
                assign prev_valid = valid_reg[k - 1];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else if (stage_ready[k])
                begin
                    valid_reg[k] <= prev_valid;
                end
            end

            always_ff @(posedge clk)
            begin
                if (stage_ready[k] && prev_valid)
                begin
                    data_reg[k] <= cipher_round(prev_data, RC);
                end
            end
        end
    endgenerate

    assign s_tready = stage_ready[0];
    assign m_tvalid = valid_reg[ROUNDS-1];
    assign m_tdata  = {data_reg[ROUNDS-1].s[8:15], data_reg[ROUNDS-1].s[0:7]};

endmodule

// File: rtl/tbce_checker.sv
// Port-level assertions for the cipher pipeline and the bind that attaches them.
module tbce_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata
);

    // A result that is not taken stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("Output valid dropped before the transfer.");

    // A result that is not taken keeps its data.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("Output data changed before the transfer.");

    // With the output side free, every stage can move, so the input side is ready.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid || m_tready |-> s_tready)
        else $error("Input stalled while the output side was free.");

    // The input side stalls only when the output register holds a waiting result.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |-> m_tvalid && !m_tready)
        else $error("Input stalled without a waiting result.");

    // Right after reset the pipeline is empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !m_tvalid)
        else $error("Output valid right after reset.");

endmodule

bind tweakable_block_cipher_encrypt tbce_checker u_tbce_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
